/* rtl/upd_pkg.sv */
`default_nettype none
package upd_pkg;

  localparam int unsigned WIN = 6;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_U_LO   = 8'h75;
  localparam logic [7:0] CH_U_UP   = 8'h55;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [2:0] USED_ONE   = 3'd1;
  localparam logic [2:0] USED_HEX   = 3'd3;
  localparam logic [2:0] USED_UNI   = 3'd6;

  // byte token between stages; a zero byte with last set marks end of string
  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } tok_t;

  typedef struct packed {
    logic [7:0] b;
    logic [2:0] used;
  } dec_t;

  typedef logic [WIN-1:0][7:0] win_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  // decision on the head byte of a window; absent bytes read as zero
  function automatic dec_t decode_head(input win_t g);
    dec_t r;
    logic [7:0] d;
    r.b = to_lower(g[0]);
    r.used = USED_ONE;
    d = 8'h00;
    if ((g[0] == CH_DOLLAR || g[0] == CH_PCT) && g[1] != 8'h00 && g[2] != 8'h00) begin
      if (is_hex(g[1]) && is_hex(g[2])) begin
        d = {hex_val(g[1]), hex_val(g[2])};
        r.used = USED_HEX;
      end else if ((g[1] == CH_U_LO || g[1] == CH_U_UP) && g[3] != 8'h00 &&
                   g[4] != 8'h00 && g[5] != 8'h00 && is_hex(g[4]) && is_hex(g[5])) begin
        d = {hex_val(g[4]), hex_val(g[5])};
        r.used = USED_UNI;
      end
      if (r.used != USED_ONE) begin
        if (d == 8'h00) begin
          d = CH_SPACE;
        end
        r.b = to_lower(d);
      end
    end else if (g[0] == CH_PLUS) begin
      r.b = CH_SPACE;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/upd_cell.sv */
`default_nettype none
module upd_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_vld,
  input  wire upd_pkg::tok_t in_tok,
  output logic               in_rdy,
  output logic               out_vld,
  output upd_pkg::tok_t      out_tok,
  input  wire logic          out_stall
);
  import upd_pkg::*;

  win_t       w_r, w_nxt, g, sh;
  logic [2*WIN-1:0][7:0] ext;
  logic [2:0] n_r, n_nxt, n1;
  logic       end_r, end_nxt;
  logic       ov_r, ov_nxt;
  tok_t       ot_r, ot_nxt;
  dec_t       dec;
  logic       want_b, want_e, slot_free, fire, acc;

  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      g[k] = (3'(k) < n_r) ? w_r[k] : 8'h00;
    end
  end

  assign dec       = decode_head(g);
  assign ext       = {{WIN{8'h00}}, w_r};
  assign want_b    = (n_r == 3'(WIN)) || (end_r && n_r != 3'd0);
  assign want_e    = end_r && n_r == 3'd0;
  assign slot_free = !ov_r || !out_stall;
  assign fire      = (want_b || want_e) && slot_free;
  assign in_rdy    = !end_r && (n_r != 3'(WIN) || (fire && want_b));
  assign acc       = in_vld && in_rdy;

  always_comb begin
    sh = w_r;
    case (dec.used)
      USED_HEX: begin
        for (int k = 0; k < WIN; k++) sh[k] = ext[k + 3];
      end
      USED_UNI: begin
        for (int k = 0; k < WIN; k++) sh[k] = ext[k + 6];
      end
      default: begin
        for (int k = 0; k < WIN; k++) sh[k] = ext[k + 1];
      end
    endcase
  end

  always_comb begin
    w_nxt   = w_r;
    n1      = n_r;
    end_nxt = end_r;
    ov_nxt  = ov_r && out_stall;
    ot_nxt  = ot_r;
    if (fire) begin
      ov_nxt = 1'b1;
      if (want_b) begin
        ot_nxt.b    = dec.b;
        ot_nxt.last = 1'b0;
        w_nxt       = sh;
        n1          = n_r - dec.used;
      end else begin
        ot_nxt.b    = 8'h00;
        ot_nxt.last = 1'b1;
        end_nxt     = 1'b0;
      end
    end
    n_nxt = n1;
    if (acc) begin
      if (in_tok.b != 8'h00) begin
        w_nxt[n1] = in_tok.b;
        n_nxt     = n1 + 3'd1;
      end
      if (in_tok.last) begin
        end_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r   <= 3'd0;
      end_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      n_r   <= n_nxt;
      end_r <= end_nxt;
      ov_r  <= ov_nxt;
    end
    w_r  <= w_nxt;
    ot_r <= ot_nxt;
  end

  assign out_vld = ov_r;
  assign out_tok = ot_r;

endmodule
`default_nettype wire

/* rtl/upd_slash.sv */
`default_nettype none
module upd_slash (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          merge_en,
  input  wire logic          in_vld,
  input  wire upd_pkg::tok_t in_tok,
  output logic               in_rdy,
  output logic               out_valid,
  output logic [7:0]         out_byte,
  output logic               out_last,
  input  wire logic          out_stall
);
  import upd_pkg::*;

  logic       held_v_r, held_v_nxt;
  logic [7:0] held_b_r, held_b_nxt;
  logic       prev_r, prev_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       ol_r, ol_nxt;
  logic [7:0] c;
  logic       drop;

  assign in_rdy = !ov_r || !out_stall;
  assign c      = (merge_en && in_tok.b == CH_BSLASH) ? CH_SLASH : in_tok.b;
  assign drop   = merge_en && c == CH_SLASH && prev_r;

  always_comb begin
    held_v_nxt = held_v_r;
    held_b_nxt = held_b_r;
    prev_nxt   = prev_r;
    ov_nxt     = ov_r && out_stall;
    ob_nxt     = ob_r;
    ol_nxt     = ol_r;
    if (in_vld && in_rdy) begin
      if (in_tok.b != 8'h00) begin
        if (!drop) begin
          prev_nxt = (c == CH_SLASH);
          if (held_v_r) begin
            ov_nxt = 1'b1;
            ob_nxt = held_b_r;
            ol_nxt = 1'b0;
          end
          held_b_nxt = c;
          held_v_nxt = 1'b1;
        end
      end else if (in_tok.last) begin
        // end of string: flush held byte as the last one
        if (held_v_r) begin
          ov_nxt = 1'b1;
          ob_nxt = held_b_r;
          ol_nxt = 1'b1;
        end
        held_v_nxt = 1'b0;
        prev_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_v_r <= 1'b0;
      prev_r   <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      held_v_r <= held_v_nxt;
      prev_r   <= prev_nxt;
      ov_r     <= ov_nxt;
    end
    held_b_r <= held_b_nxt;
    ob_r     <= ob_nxt;
    ol_r     <= ol_nxt;
  end

  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_last  = ol_r;

endmodule
`default_nettype wire

/* rtl/url_percent_decode_normalizer.sv */
// throughput: one byte per cycle inside a string while out_stall is low; the input stalls at string end
// while the first cell drains up to six bytes and hands on the end token
// buffering: each cell keeps five bytes of lookahead and the slash stage holds one byte back, so a
// byte leaves once the bytes behind it fill those; out_last comes once each cell in turn has drained
// its window and handed on the end token, and the slash stage has flushed its held byte
// reset: synchronous active-low rst_n empties the cells and the held byte, merge_enable goes to 1
`default_nettype none
module url_percent_decode_normalizer #(
  parameter int DECODE_PASSES = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            in_stall,
  output logic            out_valid,
  output logic [7:0]      out_byte,
  output logic            out_last,
  input  wire logic       out_stall
);
  import upd_pkg::*;

  // merge_enable register
  logic merge_r, merge_nxt;

  // token chain: index i feeds cell i, the last index feeds the slash stage
  logic vld [0:DECODE_PASSES];
  logic rdy [0:DECODE_PASSES];
  tok_t tok [0:DECODE_PASSES];

  assign merge_nxt = cfg_wr_en ? cfg_wr_data : merge_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      merge_r <= 1'b1;
    end else begin
      merge_r <= merge_nxt;
    end
  end

  // input transfer enters the first decode cell directly
  assign vld[0]      = in_valid;
  assign tok[0].b    = in_byte;
  assign tok[0].last = in_last;
  assign in_stall    = !rdy[0];

  // one cell per decode pass, each hands tokens to the next
  for (genvar i = 0; i < DECODE_PASSES; i++) begin : g_pass
    upd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_vld    (vld[i]),
      .in_tok    (tok[i]),
      .in_rdy    (rdy[i]),
      .out_vld   (vld[i+1]),
      .out_tok   (tok[i+1]),
      .out_stall (!rdy[i+1])
    );
  end

  // backslash fold, slash merge and hold-back of the final byte
  upd_slash u_slash (
    .clk       (clk),
    .rst_n     (rst_n),
    .merge_en  (merge_r),
    .in_vld    (vld[DECODE_PASSES]),
    .in_tok    (tok[DECODE_PASSES]),
    .in_rdy    (rdy[DECODE_PASSES]),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_stall (out_stall)
  );

endmodule
`default_nettype wire

/* rtl/upd_checker.sv */
`default_nettype none
module upd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic [7:0] out_byte,
  input wire logic       out_last,
  input wire logic       out_stall
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_byte != 8'h00)
    else $error("zero byte on output");

  a_lower: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_byte >= 8'h41 && out_byte <= 8'h5A))
    else $error("uppercase byte on output");

endmodule

bind url_percent_decode_normalizer upd_checker u_upd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_byte  (out_byte),
  .out_last  (out_last),
  .out_stall (out_stall)
);
`default_nettype wire
